@@ rtl/ppss_pkg.sv @@
//------------------------------------------------------------------------------
// ppss_pkg
// Shared types and codes for the packed page string store.
//------------------------------------------------------------------------------
package ppss_pkg;

	typedef enum logic [1:0] {
		REQ_PUT   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_OVFL  = 2'd1,
		ST_BADPG = 2'd2
	} status_t;

endpackage

@@ rtl/packed_page_string_store_core.sv @@
//------------------------------------------------------------------------------
// packed_page_string_store_core
// Numbered zero-terminated strings packed back to back in one byte memory.
//------------------------------------------------------------------------------
// Usage:
//   s_axis carries one request item: tuser = req_type, tdata = page_sel,
//   char_in, read_index (low bits up), tlast = last_char.
//   m_axis returns one result item per read, clear, final put byte or bad
//   page: tdata = read_byte, page_length, status (low bits up).
//   Non-final put bytes produce no item.
//   A read steps through offset lookup, memory read and result.
//   A commit walks the shifted tail one byte at a time (read then
//   write, as the byte memory is single-port), then writes the new
//   string one byte per cycle.
//   A clear sweeps the byte memory one entry per cycle.
//   Reset runs the same sweep; s_axis_tready stays low until it finishes.
//   A result waits in an output register; while it is not taken, the block
//   accepts no new item. store_size is written through cfg_we/cfg_wdata
//   while idle; that is up to the user, the block itself does not enforce it.
//------------------------------------------------------------------------------
module packed_page_string_store_core
	import ppss_pkg::*;
#(
	parameter int PAGE_COUNT  = 8,
	parameter int STORE_DEPTH = 256,
	parameter int MAX_STRING  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [8:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: page_sel[7:0], char_in[15:8], read_index[23:16]
	input  logic [23:0] s_axis_tdata,
	// tuser: req_type[1:0]
	input  logic [1:0]  s_axis_tuser,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: read_byte[7:0], page_length[15:8], status[17:16], zero fill
	output logic [23:0] m_axis_tdata
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int PW = $clog2(PAGE_COUNT);
	localparam int SW = $clog2(MAX_STRING);
	localparam int CW = $clog2(MAX_STRING + 1);
	localparam int OW = AW + 1;                // offsets up to STORE_DEPTH
	localparam int XW = OW + 2;                // working width with headroom
	localparam logic [XW-1:0] DEPTH_X = XW'(STORE_DEPTH);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_PREP, S_RRD, S_RDAT, S_SHRD, S_SHWR,
		S_OFS, S_WSTR, S_OUT
	} state_t;

	state_t state_q;

	// byte memory
	logic [7:0]    mem [STORE_DEPTH];
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic          mem_we;
	logic [7:0]    mem_rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		mem_rdata_q <= mem[mem_addr];
	end

	// staging memory
	logic [7:0]    stg [MAX_STRING];
	logic [SW-1:0] stg_addr;
	logic          stg_we;
	logic [7:0]    stg_rdata_q;

	always_ff @(posedge clk) begin
		if (stg_we) stg[stg_addr] <= s_axis_tdata[15:8];
		stg_rdata_q <= stg[stg_addr];
	end

	// page tables (small, held in registers)
	logic [OW-1:0] ofs_q [PAGE_COUNT];
	logic [8:0]    len_q [PAGE_COUNT];

	logic [8:0]    size_q;
	logic [CW-1:0] cnt_q;
	logic          drop_q, ended_q;
	logic [PW-1:0] page_q;
	logic [7:0]    idx_q;
	logic [XW-1:0] a_q, diff_q, pos_q, slen_q, end_q, np_q, i_q;
	logic          right_q;
	logic [1:0]    stat_q;
	logic [23:0]   out_q;
	logic          outv_q;
	logic [AW:0]   clr_q;

	// effective store size
	logic [XW-1:0] s_eff;
	always_comb begin
		s_eff = XW'(size_q);
		if (size_q < 9'd2) s_eff = XW'(2);
		if (s_eff > DEPTH_X) s_eff = DEPTH_X;
	end

	logic [1:0] in_req;
	logic [7:0] in_page, in_ch, in_idx;
	assign in_req  = s_axis_tuser;
	assign in_page = s_axis_tdata[7:0];
	assign in_ch   = s_axis_tdata[15:8];
	assign in_idx  = s_axis_tdata[23:16];

	logic acc;
	assign s_axis_tready = (state_q == S_IDLE) && !outv_q;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = outv_q;
	assign m_axis_tdata  = out_q;

	// derived values for the current page
	logic [XW-1:0] np_x, end_x, nextpos, src_a, len_sat;
	logic          last_pg;
	assign last_pg = (32'(page_q) + 1 >= PAGE_COUNT);
	assign np_x    = last_pg ? '0 : XW'(ofs_q[last_pg ? '0 : page_q + PW'(1)]);
	assign end_x   = XW'(ofs_q[PAGE_COUNT-1]) + XW'(len_q[PAGE_COUNT-1]);
	assign nextpos = pos_q + slen_q + XW'(1);
	assign len_sat = (slen_q > XW'(255)) ? XW'(255) : slen_q;
	// shift source: right shifts walk down from end, left shifts up from np
	assign src_a = a_q;

	// memory / staging port control
	always_comb begin
		mem_addr  = '0;
		mem_wdata = '0;
		mem_we    = 1'b0;
		stg_addr  = SW'(cnt_q);
		stg_we    = 1'b0;
		unique case (state_q)
			S_CLR: begin
				mem_addr = clr_q[AW-1:0];
				mem_we   = 1'b1;
			end
			S_IDLE: begin
				stg_we = acc && (in_req == REQ_PUT) && !ended_q && (in_ch != 8'd0)
				         && (cnt_q < CW'(MAX_STRING));
			end
			S_PREP: begin
				// truncation zeroes the last store byte
				mem_addr  = AW'(s_eff - XW'(1));
				mem_we    = (pos_q + slen_q >= s_eff);
			end
			S_RRD: mem_addr = AW'(a_q);
			S_SHRD: mem_addr = AW'(src_a);
			S_SHWR: begin
				mem_addr  = right_q ? AW'(a_q + diff_q) : AW'(a_q - diff_q);
				mem_wdata = mem_rdata_q;
				mem_we    = right_q ? (a_q + diff_q < s_eff) : 1'b1;
			end
			S_WSTR: begin
				stg_addr  = SW'(i_q);
				mem_addr  = AW'(pos_q + i_q - XW'(1));
				mem_wdata = (i_q - XW'(1) < slen_q) ? stg_rdata_q : 8'd0;
				mem_we    = (i_q != '0) && (pos_q + i_q - XW'(1) < s_eff - XW'(1));
			end
			default: ;
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			size_q  <= 9'd256;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			ended_q <= 1'b0;
			outv_q  <= 1'b0;
			out_q   <= '0;
			for (int k = 0; k < PAGE_COUNT; k++) begin
				ofs_q[k] <= '0;
				len_q[k] <= '0;
			end
		end else begin
			if (cfg_we) size_q <= cfg_wdata;
			if (outv_q && m_axis_tready) outv_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == STORE_DEPTH - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: if (acc) begin
					page_q <= PW'(in_page);
					idx_q  <= in_idx;
					stat_q <= ST_OK;
					case (in_req)
						REQ_PUT: begin
							if (!ended_q) begin
								if (in_ch == 8'd0) ended_q <= 1'b1;
								else if (cnt_q < CW'(MAX_STRING)) cnt_q <= cnt_q + 1'b1;
								else drop_q <= 1'b1;
							end
							if (s_axis_tlast) begin
								if (32'(in_page) >= PAGE_COUNT) begin
									out_q   <= {6'd0, ST_BADPG, 16'd0};
									outv_q  <= 1'b1;
									cnt_q   <= '0;
									drop_q  <= 1'b0;
									ended_q <= 1'b0;
								end else begin
									state_q <= S_PREP;
								end
							end
						end
						REQ_READ: begin
							if (32'(in_page) >= PAGE_COUNT) begin
								out_q  <= {6'd0, ST_BADPG, 16'd0};
								outv_q <= 1'b1;
							end else begin
								a_q <= XW'(ofs_q[PW'(in_page)]) + XW'(in_idx);
								state_q <= S_RRD;
							end
						end
						REQ_CLEAR: begin
							for (int k = 0; k < PAGE_COUNT; k++) begin
								ofs_q[k] <= '0;
								len_q[k] <= '0;
							end
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							ended_q <= 1'b0;
							clr_q   <= '0;
							out_q   <= '0;
							outv_q  <= 1'b1;
							state_q <= S_CLR;
						end
						default: ;
					endcase
				end
				S_RRD: state_q <= S_RDAT;
				S_RDAT: begin
					out_q[7:0] <= (XW'(idx_q) < XW'(len_q[page_q]) && a_q < s_eff)
					              ? mem_rdata_q : 8'd0;
					out_q[15:8]  <= (len_q[page_q] > 9'd255) ? 8'd255 : len_q[page_q][7:0];
					out_q[23:16] <= {6'd0, ST_OK};
					outv_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_PREP: begin
					// decide truncation (the block below trims slen_q); pos_q/slen_q
					// were loaded there when the final byte was taken
					state_q <= S_OFS;
				end
				S_OFS: begin
					// set up shift, go straight to string write, or report overflow
					i_q <= '0;
					if (pos_q >= s_eff) begin
						out_q   <= {6'd0, ST_OVFL, len_q[page_q] > 9'd255 ? 8'd255
						            : len_q[page_q][7:0], 8'd0};
						state_q <= S_OUT;
					end else if (last_pg || np_x == nextpos) begin
						state_q <= S_WSTR;
					end else if (np_x < nextpos) begin
						right_q <= 1'b1;
						diff_q  <= nextpos - np_x;
						np_q    <= np_x;
						end_q   <= end_x;
						a_q     <= end_x;
						state_q <= (np_x <= end_x) ? S_SHRD : S_WSTR;
						for (int k = 0; k < PAGE_COUNT; k++)
							if (k > 32'(page_q)) begin
								ofs_q[k] <= (XW'(ofs_q[k]) + nextpos - np_x > s_eff)
								            ? OW'(s_eff) : OW'(XW'(ofs_q[k]) + nextpos - np_x);
							end
					end else begin
						right_q <= 1'b0;
						diff_q  <= np_x - nextpos;
						np_q    <= np_x;
						end_q   <= end_x;
						a_q     <= np_x;
						state_q <= (np_x <= end_x && np_x < s_eff) ? S_SHRD : S_WSTR;
						for (int k = 0; k < PAGE_COUNT; k++)
							if (k > 32'(page_q)) begin
								ofs_q[k] <= (XW'(ofs_q[k]) > np_x - nextpos)
								            ? OW'(XW'(ofs_q[k]) - (np_x - nextpos)) : '0;
							end
					end
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					if (right_q) begin
						if (a_q + diff_q >= s_eff && a_q < s_eff && mem_rdata_q != 8'd0)
							stat_q <= ST_OVFL;
						if (a_q == np_q) state_q <= S_WSTR;
						else begin
							a_q <= a_q - XW'(1);
							state_q <= S_SHRD;
						end
					end else begin
						if (a_q == end_q || a_q + XW'(1) >= s_eff) state_q <= S_WSTR;
						else begin
							a_q <= a_q + XW'(1);
							state_q <= S_SHRD;
						end
					end
				end
				S_WSTR: begin
					// i_q leads the write index by one, as the staging read is registered
					i_q <= i_q + XW'(1);
					if (i_q == slen_q + XW'(1)) begin
						len_q[page_q] <= 9'(slen_q);
						for (int k = 0; k < PAGE_COUNT; k++)
							if (k > 32'(page_q) && XW'(ofs_q[k]) == pos_q)
								ofs_q[k] <= OW'(nextpos);
						out_q   <= {6'd0, stat_q, len_sat[7:0], 8'd0};
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					outv_q  <= 1'b1;
					cnt_q   <= '0;
					drop_q  <= 1'b0;
					ended_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			// commit geometry is set in the cycle the final byte is taken
			if (state_q == S_IDLE && acc && in_req == REQ_PUT && s_axis_tlast
			    && 32'(in_page) < PAGE_COUNT) begin
				pos_q <= XW'(ofs_q[PW'(in_page)]);
				slen_q <= XW'(cnt_q) + XW'((!ended_q && in_ch != 8'd0
				          && cnt_q < CW'(MAX_STRING)) ? 1 : 0);
			end
			if (state_q == S_PREP) begin
				if (drop_q) stat_q <= ST_OVFL;
				if (pos_q + slen_q >= s_eff) begin
					stat_q <= ST_OVFL;
					if (pos_q < s_eff) slen_q <= s_eff - pos_q - XW'(1);
				end
			end
		end
	end

endmodule
